// ===== design/bplsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bplsc_pkg: shared types and constants of the button panel link controller
// Time widths, button count, register indexes and reset values, and the
// result item layout used by the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bplsc_pkg;

   // Geometry
   localparam int TIME_BITS      = 32;
   localparam int BUTTON_COUNT   = 4;
   localparam int BUTTON_FIELD   = 4;
   localparam int BLINK_OFF_MS   = 50;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int BLINK_ON_BITS  = 10;
   localparam int BLINK_CNT_BITS = 4;
   // Blink period is blink_on_ms + BLINK_OFF_MS, both at most 1023
   localparam int PHASE_BITS     = 11;
   // Completed periods, saturating at the largest blink count
   localparam int QUOT_BITS      = BLINK_CNT_BITS;
   localparam int DIV_COUNT_BITS = $clog2(TIME_BITS);

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEBOUNCE     = 3'd0,
      CSR_PING_PERIOD  = 3'd1,
      CSR_LINK_TIMEOUT = 3'd2,
      CSR_ACK_FLASH    = 3'd3,
      CSR_BEEP         = 3'd4,
      CSR_BLINK_ON     = 3'd5,
      CSR_BLINK_COUNT  = 3'd6,
      CSR_BLINK_CYCLE  = 3'd7
   } csr_index_type;

   // Register reset values
   localparam logic [15:0] RST_DEBOUNCE     = 16'd50;
   localparam logic [15:0] RST_PING_PERIOD  = 16'd1000;
   localparam logic [15:0] RST_LINK_TIMEOUT = 16'd3000;
   localparam logic [15:0] RST_ACK_FLASH    = 16'd500;
   localparam logic [15:0] RST_BEEP         = 16'd100;
   localparam logic [BLINK_ON_BITS-1:0]  RST_BLINK_ON    = 10'd50;
   localparam logic [BLINK_CNT_BITS-1:0] RST_BLINK_COUNT = 4'd5;
   localparam logic [15:0] RST_BLINK_CYCLE  = 16'd2000;

   typedef logic [TIME_BITS-1:0] time_type;

   // Merge stage result
   typedef struct packed {
      logic [BUTTON_FIELD-1:0] press_mask;
      logic                    any_press;
   } merge_out_type;

   // One result item
   typedef struct packed {
      logic [BUTTON_FIELD-1:0] press_mask;
      logic                    ping_request;
      logic                    link_up;
      logic                    ack_led;
      logic                    speaker_on;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== design/bplsc_channels.sv =====
// ----------------------------------------------------------------------------
// bplsc channels: tick and result handshake interfaces
// Each carries valid, ready and the item payload, with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface bplsc_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] button_levels;
   logic       ack_seen;

   modport source (output valid, output button_levels, output ack_seen, input ready);
   modport sink   (input valid, input button_levels, input ack_seen, output ready);
endinterface

interface bplsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] press_mask;
   logic       ping_request;
   logic       link_up;
   logic       ack_led;
   logic       speaker_on;

   modport source (output valid, output press_mask, output ping_request,
                   output link_up, output ack_led, output speaker_on, input ready);
   modport sink   (input valid, input press_mask, input ping_request,
                   input link_up, input ack_led, input speaker_on, output ready);
endinterface

`default_nettype wire

// ===== design/bplsc_lane.sv =====
// ----------------------------------------------------------------------------
// bplsc_lane: debounce lane for one button
// Holds the accepted level and the time of the last accepted change, and
// flags a new press when the level drops low once that change is older than the holdoff time.
// ----------------------------------------------------------------------------
`default_nettype none

module bplsc_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tick,
   input  wire bplsc_pkg::time_type  now,
   input  wire logic                 level,
   input  wire logic [15:0]          debounce_ms,
   output logic                      press
);

   logic                stable_ff;
   bplsc_pkg::time_type last_change_ff;
   bplsc_pkg::time_type age;
   logic                change;

   // Accept a change once the last one is old enough
   always_comb begin
      age    = now - last_change_ff;
      change = (level != stable_ff) &&
               (age > {{(bplsc_pkg::TIME_BITS-16){1'b0}}, debounce_ms});
      press  = change && !level;
   end

   // Record accepted level and change time
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b1;
         last_change_ff <= '0;
      end else if (tick && change) begin
         stable_ff      <= level;
         last_change_ff <= now;
      end
   end

endmodule

`default_nettype wire

// ===== design/bplsc_merge.sv =====
// ----------------------------------------------------------------------------
// bplsc_merge: merge stage of the debounce lanes
// Packs the lane press flags into the result mask and flags any press.
// ----------------------------------------------------------------------------
`default_nettype none

module bplsc_merge (
   input  wire logic [bplsc_pkg::BUTTON_COUNT-1:0] press_bits,
   output bplsc_pkg::merge_out_type                merged
);

   // Fold lane flags into the field-wide mask
   always_comb begin
      merged.press_mask = '0;
      for (int i = 0; i < bplsc_pkg::BUTTON_COUNT; i++) begin
         if (i < bplsc_pkg::BUTTON_FIELD) begin
            merged.press_mask[i] = press_bits[i];
         end
      end
      merged.any_press = |merged.press_mask;
   end

endmodule

`default_nettype wire

// ===== design/bplsc_phase_div.sv =====
// ----------------------------------------------------------------------------
// bplsc_phase_div: blink phase divider
// Restoring divider, one quotient bit per cycle, that rebuilds the position
// within the blink period and the saturated period count for a cycle age.
// ----------------------------------------------------------------------------
`default_nettype none

module bplsc_phase_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire bplsc_pkg::time_type                 dividend,
   input  wire logic [bplsc_pkg::PHASE_BITS-1:0]    divisor,
   output logic                                     busy,
   output logic                                     done,
   output logic [bplsc_pkg::PHASE_BITS-1:0]         remainder,
   output logic [bplsc_pkg::QUOT_BITS-1:0]          quotient
);

   logic                                    run_ff;
   logic                                    done_ff;
   logic [bplsc_pkg::DIV_COUNT_BITS-1:0]    count_ff;
   bplsc_pkg::time_type                     shift_ff;
   logic [bplsc_pkg::PHASE_BITS-1:0]        rem_ff;
   logic [bplsc_pkg::QUOT_BITS-1:0]         quot_ff;

   logic [bplsc_pkg::PHASE_BITS:0]          trial;
   logic [bplsc_pkg::PHASE_BITS:0]          diff;
   logic                                    fits;
   logic [bplsc_pkg::PHASE_BITS-1:0]        rem_in;
   logic [bplsc_pkg::QUOT_BITS-1:0]         quot_in;

   // One restoring step; quotient saturates once doubling overflows
   always_comb begin
      trial  = {rem_ff, shift_ff[bplsc_pkg::TIME_BITS-1]};
      diff   = trial - {1'b0, divisor};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? diff[bplsc_pkg::PHASE_BITS-1:0] : trial[bplsc_pkg::PHASE_BITS-1:0];
      if (quot_ff[bplsc_pkg::QUOT_BITS-1]) begin
         quot_in = '1;
      end else begin
         quot_in = {quot_ff[bplsc_pkg::QUOT_BITS-2:0], fits};
      end
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && count_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Advance the datapath
   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= bplsc_pkg::DIV_COUNT_BITS'(bplsc_pkg::TIME_BITS - 1);
         shift_ff <= dividend;
         rem_ff   <= '0;
         quot_ff  <= '0;
      end else if (run_ff) begin
         count_ff <= count_ff - 1'b1;
         shift_ff <= {shift_ff[bplsc_pkg::TIME_BITS-2:0], 1'b0};
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
      end
   end

   assign busy      = run_ff || done_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;
   assign quotient  = quot_ff;

endmodule

`default_nettype wire

// ===== design/button_panel_link_status_controller.sv =====
// ----------------------------------------------------------------------------
// button_panel_link_status_controller: button panel with link watchdog
// Debounces the buttons in parallel lanes, reports new presses, times the
// beep, raises ping requests, tracks link-up and drives the acknowledge LED
// with its flash and disconnect blink bursts.
//
//   channel   dir   handshake          payload
//   req_bus   in    valid/ready        button_levels[3:0], ack_seen
//   rsp_bus   out   valid/ready        press_mask[3:0], ping_request, link_up,
//                                      ack_led, speaker_on
//   csr_*     in    csr_write_enable   csr_index[2:0], csr_write_data[15:0]
//
// One tick is taken per clock cycle while req_bus.ready is high; its result is
// registered for rsp_bus, and all state updates complete in the accept cycle.
// An output register plus a skid register let ticks flow while rsp_bus stalls;
// req_bus.ready drops when both are full or while the phase divider is busy.
// A write of blink_on_ms rebuilds the blink phase with a 32-step divider;
// ticks are held off after that write until the divider result is loaded.
// Reset is synchronous; it restores config and tick state and the valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module button_panel_link_status_controller (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   bplsc_req_if.sink                                 req_bus,
   bplsc_rsp_if.source                               rsp_bus,
   input  wire logic                                 csr_write_enable,
   input  wire logic [bplsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [bplsc_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int TB = bplsc_pkg::TIME_BITS;
   localparam int PB = bplsc_pkg::PHASE_BITS;
   localparam int QB = bplsc_pkg::QUOT_BITS;

   // Configuration registers
   logic [15:0]                             debounce_ff;
   logic [15:0]                             ping_period_ff;
   logic [15:0]                             link_timeout_ff;
   logic [15:0]                             ack_flash_ff;
   logic [15:0]                             beep_ff;
   logic [bplsc_pkg::BLINK_ON_BITS-1:0]     blink_on_ff;
   logic [bplsc_pkg::BLINK_CNT_BITS-1:0]    blink_count_ff;
   logic [15:0]                             blink_cycle_ff;

   // Tick state
   bplsc_pkg::time_type time_now_ff;
   bplsc_pkg::time_type last_ping_ff;
   bplsc_pkg::time_type last_ack_ff;
   bplsc_pkg::time_type flash_start_ff;
   bplsc_pkg::time_type cycle_start_ff;
   bplsc_pkg::time_type beep_end_ff;
   logic                flash_active_ff;
   logic                ack_led_ff;
   logic                cycle_valid_ff;
   logic                beep_active_ff;
   logic [PB-1:0]       phase_ff;
   logic [QB-1:0]       quot_ff;

   // Output register and skid
   logic                    rsp_valid_ff;
   bplsc_pkg::rsp_data_type rsp_data_ff;
   logic                    skid_valid_ff;
   bplsc_pkg::rsp_data_type skid_data_ff;

   logic                                   accept;
   logic                                   div_start;
   logic                                   div_busy;
   logic                                   div_done;
   logic [PB-1:0]                          div_rem;
   logic [QB-1:0]                          div_quot;
   logic [bplsc_pkg::BUTTON_COUNT-1:0]     lane_press;
   logic [bplsc_pkg::BUTTON_COUNT-1:0]     lane_level;
   bplsc_pkg::merge_out_type               merged;

   bplsc_pkg::time_type now;
   bplsc_pkg::time_type now_next;
   bplsc_pkg::time_type ack_time;
   bplsc_pkg::time_type flash_start_in;
   bplsc_pkg::time_type beep_end_in;
   bplsc_pkg::time_type cycle_start_in;
   bplsc_pkg::time_type cyc_age;
   logic [PB-1:0]       period;
   logic                flash_act_eff;
   logic                led_eff;
   logic                beep_act_eff;
   logic                ping_due;
   logic                link_up;
   logic                flash_end;
   logic                flash_active_in;
   logic                blink_apply;
   logic                restart;
   logic [PB-1:0]       phase_cur;
   logic [QB-1:0]       quot_cur;
   logic [PB:0]         phase_inc;
   logic [PB-1:0]       phase_in;
   logic [QB-1:0]       quot_in;
   logic                ack_led_in;
   logic                cycle_valid_in;
   logic                beep_active_in;
   bplsc_pkg::rsp_data_type result;

   assign accept  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !skid_valid_ff && !div_busy;
   assign period  = PB'(blink_on_ff) + PB'(bplsc_pkg::BLINK_OFF_MS);
   assign now     = time_now_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= bplsc_pkg::RST_DEBOUNCE;
         ping_period_ff  <= bplsc_pkg::RST_PING_PERIOD;
         link_timeout_ff <= bplsc_pkg::RST_LINK_TIMEOUT;
         ack_flash_ff    <= bplsc_pkg::RST_ACK_FLASH;
         beep_ff         <= bplsc_pkg::RST_BEEP;
         blink_on_ff     <= bplsc_pkg::RST_BLINK_ON;
         blink_count_ff  <= bplsc_pkg::RST_BLINK_COUNT;
         blink_cycle_ff  <= bplsc_pkg::RST_BLINK_CYCLE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bplsc_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_write_data;
            bplsc_pkg::CSR_PING_PERIOD:  ping_period_ff  <= csr_write_data;
            bplsc_pkg::CSR_LINK_TIMEOUT: link_timeout_ff <= csr_write_data;
            bplsc_pkg::CSR_ACK_FLASH:    ack_flash_ff    <= csr_write_data;
            bplsc_pkg::CSR_BEEP:         beep_ff         <= csr_write_data;
            bplsc_pkg::CSR_BLINK_ON:
               blink_on_ff <= csr_write_data[bplsc_pkg::BLINK_ON_BITS-1:0];
            bplsc_pkg::CSR_BLINK_COUNT:
               blink_count_ff <= csr_write_data[bplsc_pkg::BLINK_CNT_BITS-1:0];
            bplsc_pkg::CSR_BLINK_CYCLE:  blink_cycle_ff  <= csr_write_data;
         endcase
      end
   end

   // Rebuild the blink phase after a new on time; the divider steps only
   // after the write, so the registered period already holds the new value
   assign div_start = csr_write_enable && (csr_index == bplsc_pkg::CSR_BLINK_ON);

   bplsc_phase_div u_phase_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (now - cycle_start_ff),
      .divisor   (period),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem),
      .quotient  (div_quot)
   );

   // Debounce lanes
   always_comb begin
      lane_level = '0;
      for (int i = 0; i < bplsc_pkg::BUTTON_COUNT; i++) begin
         if (i < bplsc_pkg::BUTTON_FIELD) begin
            lane_level[i] = req_bus.button_levels[i];
         end
      end
   end

   for (genvar g = 0; g < bplsc_pkg::BUTTON_COUNT; g++) begin : g_lane
      bplsc_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .tick        (accept),
         .now         (now),
         .level       (lane_level[g]),
         .debounce_ms (debounce_ff),
         .press       (lane_press[g])
      );
   end

   bplsc_merge u_merge (
      .press_bits (lane_press),
      .merged     (merged)
   );

   // Tick update: ack first, then ping, link, flash, blink and beep
   always_comb begin
      now_next       = now + 1'b1;
      ack_time       = req_bus.ack_seen ? now : last_ack_ff;
      flash_start_in = req_bus.ack_seen ? now : flash_start_ff;
      flash_act_eff  = req_bus.ack_seen || flash_active_ff;
      led_eff        = req_bus.ack_seen || ack_led_ff;

      beep_end_in  = merged.any_press ? now + TB'(beep_ff) : beep_end_ff;
      beep_act_eff = merged.any_press || beep_active_ff;

      ping_due = (now - last_ping_ff) >= TB'(ping_period_ff);
      link_up  = (now - ack_time) < TB'(link_timeout_ff);

      flash_end       = flash_act_eff && ((now - flash_start_in) >= TB'(ack_flash_ff));
      flash_active_in = flash_act_eff && !flash_end;

      // Blink burst while the link is down and no flash runs
      cyc_age     = now - cycle_start_ff;
      blink_apply = !link_up && !flash_active_in;
      restart     = blink_apply && (!cycle_valid_ff || cyc_age >= TB'(blink_cycle_ff));
      phase_cur   = restart ? '0 : phase_ff;
      quot_cur    = restart ? '0 : quot_ff;

      if (blink_apply) begin
         ack_led_in = (quot_cur < blink_count_ff) && (phase_cur < PB'(blink_on_ff));
      end else begin
         ack_led_in = led_eff && !flash_end;
      end

      if (blink_apply) begin
         cycle_valid_in = 1'b1;
      end else if (link_up) begin
         cycle_valid_in = 1'b0;
      end else begin
         cycle_valid_in = cycle_valid_ff;
      end
      cycle_start_in = restart ? now : cycle_start_ff;

      // Advance phase to the next tick's cycle age
      phase_inc = {1'b0, phase_cur} + 1'b1;
      if (now_next == cycle_start_in) begin
         phase_in = '0;
         quot_in  = '0;
      end else if (phase_inc >= {1'b0, period}) begin
         phase_in = '0;
         quot_in  = (quot_cur == '1) ? quot_cur : quot_cur + 1'b1;
      end else begin
         phase_in = phase_inc[PB-1:0];
         quot_in  = quot_cur;
      end

      beep_active_in = beep_act_eff && (now != beep_end_in);

      result.press_mask   = merged.press_mask;
      result.ping_request = ping_due;
      result.link_up      = link_up;
      result.ack_led      = ack_led_in;
      result.speaker_on   = beep_active_in;
   end

   // Commit tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff     <= '0;
         last_ping_ff    <= '0;
         last_ack_ff     <= '0;
         flash_start_ff  <= '0;
         cycle_start_ff  <= '0;
         beep_end_ff     <= '0;
         flash_active_ff <= 1'b0;
         ack_led_ff      <= 1'b0;
         cycle_valid_ff  <= 1'b0;
         beep_active_ff  <= 1'b0;
         phase_ff        <= '0;
         quot_ff         <= '0;
      end else if (accept) begin
         time_now_ff     <= now_next;
         if (ping_due) begin
            last_ping_ff <= now;
         end
         last_ack_ff     <= ack_time;
         flash_start_ff  <= flash_start_in;
         cycle_start_ff  <= cycle_start_in;
         beep_end_ff     <= beep_end_in;
         flash_active_ff <= flash_active_in;
         ack_led_ff      <= ack_led_in;
         cycle_valid_ff  <= cycle_valid_in;
         beep_active_ff  <= beep_active_in;
         phase_ff        <= phase_in;
         quot_ff         <= quot_in;
      end else if (div_done) begin
         phase_ff        <= div_rem;
         quot_ff         <= div_quot;
      end
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (accept) begin
            rsp_data_ff <= result;
         end
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.press_mask   = rsp_data_ff.press_mask;
   assign rsp_bus.ping_request = rsp_data_ff.ping_request;
   assign rsp_bus.link_up      = rsp_data_ff.link_up;
   assign rsp_bus.ack_led      = rsp_data_ff.ack_led;
   assign rsp_bus.speaker_on   = rsp_data_ff.speaker_on;

   // Skid holds an item only behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // An accepted tick always leaves a result pending
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no pending result");

   // A running flash keeps the acknowledge LED lit
   a_flash_lights_led: assert property (@(posedge clock) disable iff (reset)
      flash_active_ff |-> ack_led_ff)
      else $error("flash active with acknowledge LED dark");

   // No tick enters while the blink phase is being rebuilt
   a_no_tick_during_div: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !accept)
      else $error("tick accepted during phase rebuild");

endmodule

`default_nettype wire
